// ----- sv/nsg_pkg.sv -----
// ----------------------------------------------------------------------------
// nsg_pkg
// Shared types, codes and the note period table of the step generator.
// ----------------------------------------------------------------------------
package nsg_pkg;

	localparam int TIME_IN_W = 32;
	localparam int NOTE_W    = 7;
	localparam int PERIOD_W  = 17;
	localparam int WIN_W     = 20;
	localparam int LOCK_W    = 24;
	localparam int ROM_DEPTH = 128;
	localparam int S_DATA_W  = 40;
	localparam int S_USER_W  = 2;
	localparam int M_DATA_W  = 8;
	localparam int CFG_AW    = 4;
	localparam int CFG_DW    = 32;

	// item kinds
	typedef logic [1:0] op_t;
	localparam op_t OP_TICK     = 2'd0;
	localparam op_t OP_NOTE_ON  = 2'd1;
	localparam op_t OP_NOTE_OFF = 2'd2;

	// register indexes (paddr[3:2])
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_LIMIT_PERIOD = 2'd0;
	localparam reg_idx_t REG_LIMIT_HALF   = 2'd1;
	localparam reg_idx_t REG_LOCKOUT      = 2'd2;

	localparam logic [WIN_W-1:0]  RST_LIMIT_PERIOD = 20'd10000;
	localparam logic [WIN_W-1:0]  RST_LIMIT_HALF   = 20'd5000;
	localparam logic [LOCK_W-1:0] RST_LOCKOUT      = 24'd500000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WAIT_STEP,
		ST_WAIT_WIN,
		ST_APPLY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_item;
		logic start_step;
		logic start_win;
		logic cap_step;
		logic cap_win;
		logic apply;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic tick_active;
		logic win_zero;
		logic rem_done;
		logic out_free;
	} ctrl_sts_t;

	typedef logic [PERIOD_W-1:0] rom_t [ROM_DEPTH];

	function automatic logic [PERIOD_W-1:0] base_period(input logic [3:0] semi);
		logic [PERIOD_W-1:0] b;
		case (semi)
			4'd0:    b = 17'd122312;
			4'd1:    b = 17'd115447;
			4'd2:    b = 17'd108967;
			4'd3:    b = 17'd102851;
			4'd4:    b = 17'd97079;
			4'd5:    b = 17'd91630;
			4'd6:    b = 17'd86487;
			4'd7:    b = 17'd81633;
			4'd8:    b = 17'd77051;
			4'd9:    b = 17'd72727;
			4'd10:   b = 17'd68645;
			4'd11:   b = 17'd64792;
			default: b = '0;
		endcase
		return b;
	endfunction

	// Floored period of each note: base of the semitone halved once per octave
	function automatic rom_t build_rom();
		rom_t r;
		logic [3:0] semi;
		logic [3:0] oct;
		semi = '0;
		oct  = '0;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			r[i] = base_period(semi) >> oct;
			if (semi == 4'd11) begin
				semi = '0;
				oct  = oct + 4'd1;
			end else begin
				semi = semi + 4'd1;
			end
		end
		return r;
	endfunction

	localparam rom_t PERIOD_ROM = build_rom();

endpackage

// ----- sv/nsg_rem.sv -----
// ----------------------------------------------------------------------------
// nsg_rem
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module nsg_rem #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [TIME_WIDTH-1:0]         dividend,
	input  logic [nsg_pkg::WIN_W-1:0]     divisor,
	output logic                          done,
	output logic [nsg_pkg::WIN_W-1:0]     rem
);
	import nsg_pkg::*;

	localparam int CNT_W = $clog2(TIME_WIDTH + 1);

	logic [TIME_WIDTH-1:0] a_q;
	logic [WIN_W-1:0]      d_q;
	logic [WIN_W-1:0]      rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [WIN_W:0]        trial;
	logic [WIN_W:0]        diff;
	logic [WIN_W-1:0]      rem_next;

	always_comb begin
		trial = {rem_q, a_q[TIME_WIDTH-1]};
		diff  = trial - {1'b0, d_q};
		if (trial >= {1'b0, d_q}) begin
			rem_next = diff[WIN_W-1:0];
		end else begin
			rem_next = trial[WIN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(TIME_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= dividend;
			d_q   <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			a_q   <= a_q << 1;
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	// the controller never restarts a division in flight
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("remainder restarted while busy");

endmodule

// ----- sv/nsg_dp.sv -----
// ----------------------------------------------------------------------------
// nsg_dp
// Datapath: item register, tone and limit state, remainder unit, output.
// ----------------------------------------------------------------------------
module nsg_dp #(
	parameter int NOTE_COUNT = 128,
	parameter int TIME_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nsg_pkg::ctrl_cmd_t            cmd,
	output nsg_pkg::ctrl_sts_t            sts,
	input  logic [nsg_pkg::S_DATA_W-1:0]  in_data,
	input  logic [nsg_pkg::S_USER_W-1:0]  in_user,
	input  logic [nsg_pkg::WIN_W-1:0]     limit_check_period,
	input  logic [nsg_pkg::WIN_W-1:0]     limit_check_half,
	input  logic [nsg_pkg::LOCK_W-1:0]    reverse_lockout,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [nsg_pkg::M_DATA_W-1:0]  out_data
);
	import nsg_pkg::*;

	// item register
	op_t                   op_q;
	logic [TIME_WIDTH-1:0] t_q;
	logic [NOTE_W-1:0]     note_q;
	logic                  closed_q;

	// tone and limit state
	logic [PERIOD_W-1:0]   period_q;
	logic [PERIOD_W-1:0]   half_q;
	logic                  step_q;
	logic                  phase_q;
	logic [TIME_WIDTH-1:0] lockout_q;
	logic                  dir_q;
	logic                  en_q;

	// per-tick intermediates
	logic                  step_new_q;
	logic                  phase_new_q;

	// result register
	logic                  out_valid_q;
	logic [2:0]            out_q;

	logic [WIN_W-1:0]      rem;
	logic                  rem_done;
	logic [WIN_W-1:0]      divisor;
	logic [PERIOD_W-1:0]   rom_period;
	logic [TIME_WIDTH-1:0] lock_sum;
	logic                  flip;

	assign divisor = cmd.start_win ? limit_check_period : WIN_W'(period_q);

	nsg_rem #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_step | cmd.start_win),
		.dividend (t_q),
		.divisor  (divisor),
		.done     (rem_done),
		.rem      (rem)
	);

	always_comb begin
		if ({1'b0, note_q} < 8'(NOTE_COUNT)) begin
			rom_period = PERIOD_ROM[note_q];
		end else begin
			rom_period = '0;
		end
		lock_sum = t_q + TIME_WIDTH'(reverse_lockout);
		flip     = phase_new_q && !phase_q && (t_q > lockout_q) && closed_q;
	end

	assign sts.tick_active = (op_q == OP_TICK) && (period_q != '0);
	assign sts.win_zero    = (limit_check_period == '0);
	assign sts.rem_done    = rem_done;
	assign sts.out_free    = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q     <= in_user;
			t_q      <= TIME_WIDTH'(in_data[31:0]);
			note_q   <= in_data[38:32];
			closed_q <= in_data[39];
		end
		if (cmd.cap_step) begin
			step_new_q <= (rem <= WIN_W'(half_q));
		end
		if (cmd.cap_win) begin
			if (limit_check_period == '0) begin
				phase_new_q <= (t_q <= TIME_WIDTH'(limit_check_half));
			end else begin
				phase_new_q <= (rem <= limit_check_half);
			end
		end
		if (cmd.load_out) begin
			out_q <= {en_q, dir_q, step_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= '0;
			half_q      <= '0;
			step_q      <= 1'b0;
			phase_q     <= 1'b0;
			lockout_q   <= '0;
			dir_q       <= 1'b0;
			en_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.apply) begin
				case (op_q)
					OP_NOTE_ON: begin
						en_q      <= 1'b1;
						period_q  <= rom_period;
						half_q    <= rom_period >> 1;
						step_q    <= 1'b0;
						phase_q   <= 1'b0;
						lockout_q <= '0;
					end
					OP_NOTE_OFF: begin
						en_q      <= 1'b0;
						period_q  <= '0;
						half_q    <= '0;
						step_q    <= 1'b0;
						phase_q   <= 1'b0;
						lockout_q <= '0;
					end
					OP_TICK: begin
						if (period_q != '0) begin
							step_q  <= step_new_q;
							phase_q <= phase_new_q;
							if (flip) begin
								dir_q     <= !dir_q;
								lockout_q <= lock_sum;
							end
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = M_DATA_W'(out_q);

	a_half_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		half_q == (period_q >> 1))
		else $error("half period out of step with period");

	a_silent_when_off: assert property (@(posedge clk) disable iff (!arst_n)
		!en_q |-> (period_q == '0))
		else $error("period set while disabled");

endmodule

// ----- sv/nsg_ctrl.sv -----
// ----------------------------------------------------------------------------
// nsg_ctrl
// Sequencer: accepts an item, runs the remainders of a tick, commits, emits.
// ----------------------------------------------------------------------------
module nsg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  nsg_pkg::ctrl_sts_t sts,
	output nsg_pkg::ctrl_cmd_t cmd
);
	import nsg_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.tick_active) begin
					cmd.start_step = 1'b1;
					state_d        = ST_WAIT_STEP;
				end else begin
					state_d = ST_APPLY;
				end
			end
			ST_WAIT_STEP: begin
				if (sts.rem_done) begin
					cmd.cap_step = 1'b1;
					if (sts.win_zero) begin
						cmd.cap_win = 1'b1;
						state_d     = ST_APPLY;
					end else begin
						cmd.start_win = 1'b1;
						state_d       = ST_WAIT_WIN;
					end
				end
			end
			ST_WAIT_WIN: begin
				if (sts.rem_done) begin
					cmd.cap_win = 1'b1;
					state_d     = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/note_stepper_step_generator_core.sv -----
// ----------------------------------------------------------------------------
// note_stepper_step_generator_core
// Stepper tone generator: note items set the step period, tick items update
// step level and limit-switch driven direction.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  s_axis    in         s_axis_tvalid/tready       tuser: operation
//                                                  tdata: time_us, note, limit_closed
//  m_axis    out        m_axis_tvalid/tready       tdata: step_level, direction, enable
//  apb       in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Sequence: a note item or an idle tick passes from accept through decode
// and apply to the result. An active tick runs the shared bit-serial
// remainder unit twice (time mod step period, then time mod window
// length); one pass when the window length is zero. Reset clears all
// tone state and loads register defaults.
// A result waits in the output register while the next item is accepted;
// a stalled output holds the sequencer only at its final step.
// ----------------------------------------------------------------------------
module note_stepper_step_generator_core #(
	parameter int NOTE_COUNT = 128,
	parameter int TIME_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input items
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [31:0] time_us, [38:32] note, [39] limit_closed
	input  logic [nsg_pkg::S_DATA_W-1:0]  s_axis_tdata,
	// [1:0] operation
	input  logic [nsg_pkg::S_USER_W-1:0]  s_axis_tuser,
	// result items
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [0] step_level, [1] direction, [2] enable
	output logic [nsg_pkg::M_DATA_W-1:0]  m_axis_tdata,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nsg_pkg::CFG_AW-1:0]    paddr,
	input  logic [nsg_pkg::CFG_DW-1:0]    pwdata,
	output logic [nsg_pkg::CFG_DW-1:0]    prdata,
	output logic                          pready
);
	import nsg_pkg::*;

	logic [WIN_W-1:0]  limit_period_q;
	logic [WIN_W-1:0]  limit_half_q;
	logic [LOCK_W-1:0] lockout_len_q;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;
	ctrl_cmd_t         cmd;
	ctrl_sts_t         sts;

	// Register file: write on the access phase; pready never stalls
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_period_q <= RST_LIMIT_PERIOD;
			limit_half_q   <= RST_LIMIT_HALF;
			lockout_len_q  <= RST_LOCKOUT;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_LIMIT_PERIOD: limit_period_q <= pwdata[WIN_W-1:0];
				REG_LIMIT_HALF:   limit_half_q   <= pwdata[WIN_W-1:0];
				REG_LOCKOUT:      lockout_len_q  <= pwdata[LOCK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read back: unmapped offsets return zero
	always_comb begin
		unique case (cfg_idx)
			REG_LIMIT_PERIOD: prdata = CFG_DW'(limit_period_q);
			REG_LIMIT_HALF:   prdata = CFG_DW'(limit_half_q);
			REG_LOCKOUT:      prdata = CFG_DW'(lockout_len_q);
			default:          prdata = '0;
		endcase
	end

	nsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	nsg_dp #(
		.NOTE_COUNT (NOTE_COUNT),
		.TIME_WIDTH (TIME_WIDTH)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.in_data            (s_axis_tdata),
		.in_user            (s_axis_tuser),
		.limit_check_period (limit_period_q),
		.limit_check_half   (limit_half_q),
		.reverse_lockout    (lockout_len_q),
		.out_valid          (m_axis_tvalid),
		.out_ready          (m_axis_tready),
		.out_data           (m_axis_tdata)
	);

	// one item in flight: ready drops right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("item accepted while another is in work");

	// a new result never overwrites one that was not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result register overwritten");

endmodule
